// File: hw/rtl/frng_pkg.sv
// ============================================================================
// frng_pkg
// Shared widths, register indexes and controller/datapath link types for the
// frame RMS noise gate.
// ============================================================================
package frng_pkg;

    // Field widths.
    localparam int SAMPLE_W   = 16;
    localparam int RMS_W      = 16;
    localparam int THR_W      = 16;
    localparam int HANG_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Frame length limit and derived arithmetic widths.
    localparam int FRAME_MAX  = 512;
    localparam int CNT_W      = $clog2(FRAME_MAX + 1);
    localparam int MAG_W      = SAMPLE_W + 1;
    localparam int SQ_W       = 2 * SAMPLE_W - 1;
    localparam int SUM_W      = SQ_W + $clog2(FRAME_MAX);
    localparam int RAD_W      = 2 * RMS_W;
    localparam int SQRT_STEPS = RAD_W / 2;
    localparam int SREM_W     = RMS_W + 2;
    localparam int STEP_W     = $clog2(SUM_W);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GATE_ENABLE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GATE_THRESHOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HANGOVER_FRAMES = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_square;
        logic accumulate;
        logic div_load;
        logic div_step;
        logic sqrt_load;
        logic sqrt_step;
        logic gate_update;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic frame_end;
        logic out_free;
    } t_dp_sts;

endpackage

// File: hw/rtl/frng_intf.sv
// ============================================================================
// frng_intf
// Valid/ready channel interfaces: sample input, result output and register
// write port.
// ============================================================================
interface frng_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [frng_pkg::SAMPLE_W-1:0] sample;
    logic                                last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface frng_out_if;
    logic                         valid;
    logic                         ready;
    logic [frng_pkg::RMS_W-1:0]   rms;
    logic                         send_previous;
    logic                         send_current;

    modport source (output valid, output rms, output send_previous, output send_current,
                    input ready);
    modport sink   (input valid, input rms, input send_previous, input send_current,
                    output ready);
endinterface

interface frng_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [frng_pkg::CFG_IDX_W-1:0]    index;
    logic [frng_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/frng_ctrl.sv
// ============================================================================
// frng_ctrl
// Sequencer: takes one sample at a time, then at frame end steps the divider
// and the square root unit and finally the gate update.
// ============================================================================
module frng_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output frng_pkg::t_dp_cmd o_cmd,
    input  frng_pkg::t_dp_sts i_sts
);

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_ACC       = 7'b0000010,
        S_DIV_LOAD  = 7'b0000100,
        S_DIV       = 7'b0001000,
        S_SQRT_LOAD = 7'b0010000,
        S_SQRT      = 7'b0100000,
        S_GATE      = 7'b1000000
    } t_state;

    t_state                          r_state, n_state;
    logic [frng_pkg::STEP_W-1:0]     r_step, n_step;
    logic                            w_div_last;
    logic                            w_sqrt_last;

    assign w_div_last  = (r_step == frng_pkg::STEP_W'(frng_pkg::SUM_W - 1));
    assign w_sqrt_last = (r_step == frng_pkg::STEP_W'(frng_pkg::SQRT_STEPS - 1));
    assign o_in_ready  = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_square = 1'b1;
                    n_state           = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.accumulate = 1'b1;
                n_state          = i_sts.frame_end ? S_DIV_LOAD : S_IDLE;
            end
            S_DIV_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_step         = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (w_div_last) begin
                    n_state = S_SQRT_LOAD;
                end
            end
            S_SQRT_LOAD: begin
                o_cmd.sqrt_load = 1'b1;
                n_step          = '0;
                n_state         = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_step          = r_step + 1'b1;
                if (w_sqrt_last) begin
                    n_state = S_GATE;
                end
            end
            S_GATE: begin
                // Hold here until the result register can take the new item.
                if (i_sts.out_free) begin
                    o_cmd.gate_update = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

// File: hw/rtl/frng_dp.sv
// ============================================================================
// frng_dp
// Datapath: sample squaring and accumulation, bit-serial divider, two-bit
// per step square root, gate state, configuration and result registers.
// ============================================================================
module frng_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  frng_pkg::t_dp_cmd                    i_cmd,
    output frng_pkg::t_dp_sts                    o_sts,
    input  logic signed [frng_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                 i_last_sample,
    input  logic                                 i_cfg_valid,
    input  logic [frng_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [frng_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic [frng_pkg::RMS_W-1:0]           o_rms,
    output logic                                 o_send_previous,
    output logic                                 o_send_current
);

    // Configuration.
    logic                          r_gate_enable;
    logic [frng_pkg::THR_W-1:0]    r_gate_threshold;
    logic [frng_pkg::HANG_W-1:0]   r_hangover_frames;

    // Accumulation.
    logic [frng_pkg::MAG_W-1:0]    w_mag;
    logic [2*frng_pkg::MAG_W-1:0]  w_sq;
    logic [frng_pkg::SQ_W-1:0]     r_sq;
    logic                          r_last;
    logic [frng_pkg::SUM_W-1:0]    r_sum;
    logic [frng_pkg::CNT_W-1:0]    r_count;

    // Divider: the dividend register shifts out dividend bits and in quotient bits.
    logic [frng_pkg::SUM_W-1:0]    r_div_num;
    logic [frng_pkg::CNT_W-1:0]    r_div_den;
    logic [frng_pkg::CNT_W-1:0]    r_div_rem;
    logic [frng_pkg::CNT_W:0]      w_rem_sh;
    logic                          w_qbit;

    // Square root.
    logic [frng_pkg::RAD_W-1:0]    r_rad;
    logic [frng_pkg::RMS_W-1:0]    r_root;
    logic [frng_pkg::SREM_W-1:0]   r_srem;
    logic [frng_pkg::SREM_W+1:0]   w_srem_sh;
    logic [frng_pkg::SREM_W+1:0]   w_trial;
    logic                          w_rbit;

    // Gate.
    logic                          r_gate_active;
    logic [frng_pkg::HANG_W-1:0]   r_hang_left;
    logic                          r_have_prev;
    logic                          w_loud;
    logic                          n_gate_active;
    logic [frng_pkg::HANG_W-1:0]   n_hang_left;
    logic                          w_send_prev;

    // Result register.
    logic                          r_out_valid;
    logic [frng_pkg::RMS_W-1:0]    r_out_rms;
    logic                          r_out_prev;
    logic                          r_out_cur;

    assign w_mag = i_sample[frng_pkg::SAMPLE_W-1]
                 ? (frng_pkg::MAG_W'(0) - {1'b1, i_sample})
                 : {1'b0, i_sample};
    assign w_sq  = w_mag * w_mag;

    assign w_rem_sh = {r_div_rem, r_div_num[frng_pkg::SUM_W-1]};
    assign w_qbit   = (w_rem_sh >= {1'b0, r_div_den});

    assign w_srem_sh = {r_srem, r_rad[frng_pkg::RAD_W-1 -: 2]};
    assign w_trial   = {2'b00, r_root, 2'b01};
    assign w_rbit    = (w_srem_sh >= w_trial);

    assign w_loud = !r_gate_enable || (r_root >= r_gate_threshold);

    always_comb begin
        n_gate_active = r_gate_active;
        n_hang_left   = r_hang_left;
        w_send_prev   = 1'b0;
        priority if (w_loud) begin
            if (!r_gate_active) begin
                w_send_prev   = r_have_prev;
                n_gate_active = 1'b1;
            end
            n_hang_left = r_hangover_frames;
        end else if (r_gate_active && (r_hang_left != '0)) begin
            n_hang_left = r_hang_left - 1'b1;
        end else if (r_gate_active) begin
            n_gate_active = 1'b0;
        end
    end

    assign o_sts.frame_end = r_last ||
                             (r_count == frng_pkg::CNT_W'(frng_pkg::FRAME_MAX - 1));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_rms           = r_out_rms;
    assign o_send_previous = r_out_prev;
    assign o_send_current  = r_out_cur;

    // Control and model state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate_enable     <= 1'b1;
            r_gate_threshold  <= '0;
            r_hangover_frames <= '0;
            r_sum             <= '0;
            r_count           <= '0;
            r_gate_active     <= 1'b0;
            r_hang_left       <= '0;
            r_have_prev       <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    frng_pkg::REG_GATE_ENABLE:     r_gate_enable     <= i_cfg_data[0];
                    frng_pkg::REG_GATE_THRESHOLD:  r_gate_threshold  <= i_cfg_data;
                    frng_pkg::REG_HANGOVER_FRAMES: r_hangover_frames <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.accumulate) begin
                r_sum   <= r_sum + frng_pkg::SUM_W'(r_sq);
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.div_load) begin
                r_sum   <= '0;
                r_count <= '0;
            end
            if (i_cmd.gate_update) begin
                r_gate_active <= n_gate_active;
                r_hang_left   <= n_hang_left;
                r_have_prev   <= 1'b1;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Arithmetic payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_square) begin
            r_sq   <= w_sq[frng_pkg::SQ_W-1:0];
            r_last <= i_last_sample;
        end
        if (i_cmd.div_load) begin
            r_div_num <= r_sum;
            r_div_den <= r_count;
            r_div_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_div_num <= {r_div_num[frng_pkg::SUM_W-2:0], w_qbit};
            r_div_rem <= w_qbit ? frng_pkg::CNT_W'(w_rem_sh - {1'b0, r_div_den})
                                : w_rem_sh[frng_pkg::CNT_W-1:0];
        end
        if (i_cmd.sqrt_load) begin
            // The quotient never exceeds the full-scale square, so it fits the radicand.
            r_rad  <= r_div_num[frng_pkg::RAD_W-1:0];
            r_root <= '0;
            r_srem <= '0;
        end
        if (i_cmd.sqrt_step) begin
            r_rad  <= {r_rad[frng_pkg::RAD_W-3:0], 2'b00};
            r_root <= {r_root[frng_pkg::RMS_W-2:0], w_rbit};
            r_srem <= w_rbit ? frng_pkg::SREM_W'(w_srem_sh - w_trial)
                             : w_srem_sh[frng_pkg::SREM_W-1:0];
        end
        if (i_cmd.gate_update) begin
            r_out_rms  <= r_root;
            r_out_prev <= w_send_prev;
            r_out_cur  <= n_gate_active;
        end
    end

endmodule

// File: hw/rtl/frame_rms_noise_gate.sv
// ============================================================================
// frame_rms_noise_gate
// Frame RMS level meter with a threshold noise gate and hangover.
// ============================================================================
// Usage:
// Samples enter on i_in (valid/ready) with a flag on the last sample of each
// frame; a frame also ends at its 512th sample. Each sample is squared into a
// register and then added to the frame sum, and i_in is not ready while it
// is being added. On the sample that ends a frame the block runs a
// one-bit-per-cycle divider for the mean square and a two-bit per step
// square root, then updates the gate and loads the result item into the
// output register; i_in stays not ready until then. Each frame gives one
// item on o_out: rms, send_previous and send_current.
// Configuration writes on i_cfg are always taken (ready held high) and
// should only be made while the block is idle.
// Reset clears the frame sum, the gate (closed), the hangover count and the
// previous-frame flag, and loads the register defaults. A result waits in
// the output register while o_out is stalled; a frame end that arrives then
// waits in its last step until the register is free.
// ============================================================================
module frame_rms_noise_gate (
    input  logic         i_clk,
    input  logic         i_rst_n,
    frng_in_if.sink      i_in,
    frng_out_if.source   o_out,
    frng_cfg_if.sink     i_cfg
);

    frng_pkg::t_dp_cmd w_cmd;
    frng_pkg::t_dp_sts w_sts;

    assign i_cfg.ready = 1'b1;

    frng_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    frng_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_sample        (i_in.sample),
        .i_last_sample   (i_in.last_sample),
        .i_cfg_valid     (i_cfg.valid),
        .i_cfg_index     (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_rms           (o_out.rms),
        .o_send_previous (o_out.send_previous),
        .o_send_current  (o_out.send_current)
    );

endmodule

// File: hw/rtl/frng_checker.sv
// ============================================================================
// frng_checker
// Port-level checks on the noise gate: result consistency, stall behavior and
// sample pacing.
// ============================================================================
module frng_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [frng_pkg::RMS_W-1:0]     i_rms,
    input logic                           i_send_previous,
    input logic                           i_send_current
);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_rms) && $stable(i_send_previous) &&
             $stable(i_send_current)))
        else $error("result changed while stalled");

    // Forwarding the previous frame only happens when the gate is open.
    a_prev_needs_cur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (!i_send_previous || i_send_current))
        else $error("send_previous without send_current");

    // The root of a mean of 16-bit squares never exceeds full scale.
    a_rms_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_rms <= 16'h8000))
        else $error("rms above full scale");

    // In the cycle after a sample is taken i_in is not ready, as that sample is still being accumulated.
    a_in_pacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("sample accepted in consecutive cycles");

endmodule

bind frame_rms_noise_gate frng_checker u_frng_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_rms           (o_out.rms),
    .i_send_previous (o_out.send_previous),
    .i_send_current  (o_out.send_current)
);
